/* src/chrb_pkg.sv */
// Package for the chunk reorder buffer: op and status codes, FSM states,
// the stored entry layout and the command/status structs between controller
// and datapath. No dependencies.
`timescale 1ns / 1ps

package chrb_pkg;

  // Operation codes carried on in_op
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CHECK  = 2'd2
  } op_t;

  // Status codes, insert
  localparam logic [1:0] INS_OK     = 2'd0;
  localparam logic [1:0] INS_REJECT = 2'd1;
  localparam logic [1:0] INS_BEYOND = 2'd2;
  localparam logic [1:0] INS_FULL   = 2'd3;
  // Status codes, pop
  localparam logic [1:0] POP_DELIVERED = 2'd0;
  localparam logic [1:0] POP_NONE      = 2'd1;
  localparam logic [1:0] POP_TOO_LONG  = 2'd2;
  // Status codes, gap check
  localparam logic [1:0] CHK_GAP  = 2'd0;
  localparam logic [1:0] CHK_NONE = 2'd1;

  // Most missing numbers one check may report
  localparam logic [6:0] MAX_GAPS = 7'd64;
  // Reset value of the gap report limit
  localparam logic [6:0] LIMIT_RESET = 7'd16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_EV,
    S_POP_EV,
    S_CHK_TEST,
    S_CHK_EV,
    S_CHK_END
  } state_t;

  // Which result word the output register loads
  typedef enum logic [2:0] {
    EM_NONE,
    EM_INSERT,
    EM_POP,
    EM_GAP,
    EM_END
  } emit_t;

  // One slot of the chunk store
  typedef struct packed {
    logic        valid;
    logic [15:0] len;
    logic [3:0]  path;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic  clear_step;
    logic  latch;
    logic  rd_slot;
    logic  ins_commit;
    logic  pop_commit;
    logic  walk_init;
    logic  walk_rd;
    logic  walk_skip;
    logic  walk_gap;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic ins_ok;
    logic pop_ok;
    logic walk_more;
    logic slot_valid;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/chunk_reorder_buffer.sv */
// Chunk reorder buffer top level: ties the controller to the datapath.
// Depends on chrb_pkg, chrb_ctrl and chrb_dp.
`timescale 1ns / 1ps

// Holds out-of-order chunks, each in the slot given by its offset from the
// next expected chunk number, for numbers up to DEPTH - 1 above it. After
// reset a clearing pass empties every slot before the first word is taken;
// config writes are taken throughout. Insert and pop first do the registered
// read of the addressed slot, then decide, write back and load the result
// word once the output register is free. A check walks the slots from the
// expected number upward, one slot at a time through the single read port;
// it stops at the highest held chunk or once gap_report_limit gaps are
// found. Results leave through one output register, so the next word is
// taken while a result still waits. Op 3 gives no result.
module chunk_reorder_buffer #(
  parameter int DEPTH      = 64,
  parameter int MAX_LENGTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_chunk_number,
  input  logic [15:0] in_chunk_length,
  input  logic [3:0]  in_path_number,
  input  logic [31:0] in_payload_handle,
  input  logic [15:0] in_room_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_chunk_number,
  output logic [3:0]  out_path_number,
  output logic [15:0] out_length,
  output logic [31:0] out_payload_handle,
  output logic        out_last
);

  chrb_pkg::ctrl_cmd_t cmd;
  chrb_pkg::dp_stat_t  stat;

  // Sequencer
  chrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot store and result path
  chrb_dp #(
    .DEPTH      (DEPTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_op),
    .in_chunk_number    (in_chunk_number),
    .in_chunk_length    (in_chunk_length),
    .in_path_number     (in_path_number),
    .in_payload_handle  (in_payload_handle),
    .in_room_bytes      (in_room_bytes),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_chunk_number   (out_chunk_number),
    .out_path_number    (out_path_number),
    .out_length         (out_length),
    .out_payload_handle (out_payload_handle),
    .out_last           (out_last)
  );

endmodule

/* src/chrb_ctrl.sv */
// Controller for the chunk reorder buffer: sequences clear, insert, pop and
// gap walk. Depends on chrb_pkg.
`timescale 1ns / 1ps

module chrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  input  chrb_pkg::dp_stat_t  stat,
  output chrb_pkg::ctrl_cmd_t cmd
);

  chrb_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chrb_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chrb_pkg::S_CLEAR: begin
        if (stat.clear_last) state_nxt = chrb_pkg::S_IDLE;
      end
      chrb_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == chrb_pkg::OP_INSERT) state_nxt = chrb_pkg::S_INS_EV;
          else if (in_op == chrb_pkg::OP_POP) state_nxt = chrb_pkg::S_POP_EV;
          else if (in_op == chrb_pkg::OP_CHECK) state_nxt = chrb_pkg::S_CHK_TEST;
        end
      end
      chrb_pkg::S_INS_EV, chrb_pkg::S_POP_EV: begin
        if (stat.out_free) state_nxt = chrb_pkg::S_IDLE;
      end
      chrb_pkg::S_CHK_TEST: begin
        state_nxt = stat.walk_more ? chrb_pkg::S_CHK_EV : chrb_pkg::S_CHK_END;
      end
      chrb_pkg::S_CHK_EV: begin
        if (stat.slot_valid || !stat.pend_valid || stat.out_free) begin
          state_nxt = chrb_pkg::S_CHK_TEST;
        end
      end
      chrb_pkg::S_CHK_END: begin
        if (stat.out_free) state_nxt = chrb_pkg::S_IDLE;
      end
      default: state_nxt = chrb_pkg::S_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    cmd.emit = chrb_pkg::EM_NONE;
    in_stall = (state_r != chrb_pkg::S_IDLE);
    unique case (state_r)
      chrb_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      chrb_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (in_op == chrb_pkg::OP_INSERT || in_op == chrb_pkg::OP_POP) begin
            cmd.rd_slot = 1'b1;
          end else if (in_op == chrb_pkg::OP_CHECK) begin
            cmd.walk_init = 1'b1;
          end
        end
      end
      chrb_pkg::S_INS_EV: begin
        if (stat.out_free) begin
          cmd.emit       = chrb_pkg::EM_INSERT;
          cmd.ins_commit = stat.ins_ok;
        end
      end
      chrb_pkg::S_POP_EV: begin
        if (stat.out_free) begin
          cmd.emit       = chrb_pkg::EM_POP;
          cmd.pop_commit = stat.pop_ok;
        end
      end
      chrb_pkg::S_CHK_TEST: begin
        cmd.walk_rd = stat.walk_more;
      end
      chrb_pkg::S_CHK_EV: begin
        // held slot: count it; empty slot: emit any earlier pending gap and park this one as the pending gap
        if (stat.slot_valid) begin
          cmd.walk_skip = 1'b1;
        end else if (!stat.pend_valid) begin
          cmd.walk_gap = 1'b1;
        end else if (stat.out_free) begin
          cmd.walk_gap = 1'b1;
          cmd.emit     = chrb_pkg::EM_GAP;
        end
      end
      chrb_pkg::S_CHK_END: begin
        if (stat.out_free) cmd.emit = chrb_pkg::EM_END;
      end
      default: begin
        cmd.emit = chrb_pkg::EM_NONE;
      end
    endcase
  end

endmodule

/* src/chrb_dp.sv */
// Datapath for the chunk reorder buffer: slot store, window registers, gap
// walk counters, config register and the output word register.
// Depends on chrb_pkg.
`timescale 1ns / 1ps

module chrb_dp #(
  parameter int DEPTH      = 64,
  parameter int MAX_LENGTH = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chrb_pkg::ctrl_cmd_t cmd,
  output chrb_pkg::dp_stat_t  stat,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_chunk_number,
  input  logic [15:0]         in_chunk_length,
  input  logic [3:0]          in_path_number,
  input  logic [31:0]         in_payload_handle,
  input  logic [15:0]         in_room_bytes,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [31:0]         out_chunk_number,
  output logic [3:0]          out_path_number,
  output logic [15:0]         out_length,
  output logic [31:0]         out_payload_handle,
  output logic                out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  // Window and config state
  logic [31:0]   exp_r;
  logic [IW-1:0] head_r;
  logic [CW-1:0] held_r;
  logic [6:0]    limit_r;
  // Latched input word
  logic [31:0]   num_r;
  logic [15:0]   len_r;
  logic [3:0]    path_r;
  logic [31:0]   handle_r;
  logic [15:0]   room_r;
  logic [IW-1:0] idx_r;
  // Gap walk
  logic [IW-1:0] walk_idx_r;
  logic [CW-1:0] walk_k_r;
  logic [CW-1:0] seen_r;
  logic [6:0]    found_r;
  logic          pend_r;
  logic [31:0]   pend_num_r;
  // Clear sweep
  logic [IW-1:0] clr_idx_r;
  // Slot store
  chrb_pkg::entry_t mem [DEPTH];
  chrb_pkg::entry_t rd_data_r;
  chrb_pkg::entry_t wr_data;
  logic [IW-1:0]    rd_idx, wr_idx, ins_idx;
  logic             rd_en, wr_en;
  // Output word register
  logic        out_valid_r;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_num_r, out_num_nxt;
  logic [3:0]  out_path_r, out_path_nxt;
  logic [15:0] out_len_r, out_len_nxt;
  logic [31:0] out_handle_r, out_handle_nxt;
  logic        out_last_r, out_last_nxt;

  logic [31:0]   off_in, off_r;
  logic [IW:0]   ins_sum;
  logic [6:0]    limit_eff;
  logic [1:0]    ins_status, pop_status;
  logic          out_free;

  // Slot of an arriving chunk number: head plus offset, wrapped once
  assign off_in  = in_chunk_number - exp_r;
  assign ins_sum = {1'b0, head_r} + {1'b0, off_in[IW-1:0]};
  assign ins_idx = (ins_sum >= (IW + 1)'(DEPTH)) ? IW'(ins_sum - (IW + 1)'(DEPTH))
                                                 : ins_sum[IW-1:0];

  // Insert verdict, order of checks matters
  assign off_r = num_r - exp_r;
  always_comb begin
    priority if (len_r == 16'd0 || len_r > 16'(MAX_LENGTH)) ins_status = chrb_pkg::INS_REJECT;
    else if (num_r < exp_r) ins_status = chrb_pkg::INS_REJECT;
    else if (off_r >= 32'(DEPTH)) ins_status = chrb_pkg::INS_BEYOND;
    else if (held_r >= CW'(DEPTH)) ins_status = chrb_pkg::INS_FULL;
    else if (rd_data_r.valid) ins_status = chrb_pkg::INS_REJECT;
    else ins_status = chrb_pkg::INS_OK;
  end

  // Pop verdict: head slot holds the expected chunk only if valid
  always_comb begin
    priority if (!rd_data_r.valid) pop_status = chrb_pkg::POP_NONE;
    else if (rd_data_r.len > room_r) pop_status = chrb_pkg::POP_TOO_LONG;
    else pop_status = chrb_pkg::POP_DELIVERED;
  end

  assign limit_eff = (limit_r > chrb_pkg::MAX_GAPS) ? chrb_pkg::MAX_GAPS : limit_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign stat.clear_last = (clr_idx_r == LAST_IDX);
  assign stat.ins_ok     = (ins_status == chrb_pkg::INS_OK);
  assign stat.pop_ok     = (pop_status == chrb_pkg::POP_DELIVERED);
  assign stat.walk_more  = (seen_r < held_r) && (found_r < limit_eff);
  assign stat.slot_valid = rd_data_r.valid;
  assign stat.pend_valid = pend_r;
  assign stat.out_free   = out_free;

  // Store port selection
  assign rd_en  = cmd.rd_slot || cmd.walk_rd;
  assign rd_idx = cmd.walk_rd ? walk_idx_r
                : ((in_op == chrb_pkg::OP_POP) ? head_r : ins_idx);
  assign wr_en  = cmd.clear_step || cmd.ins_commit || cmd.pop_commit;
  assign wr_idx = cmd.clear_step ? clr_idx_r : idx_r;
  always_comb begin
    wr_data = '0;
    if (cmd.ins_commit) begin
      wr_data.valid  = 1'b1;
      wr_data.len    = len_r;
      wr_data.path   = path_r;
      wr_data.handle = handle_r;
    end
  end

  // Slot store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_idx];
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      num_r    <= in_chunk_number;
      len_r    <= in_chunk_length;
      path_r   <= in_path_number;
      handle_r <= in_payload_handle;
      room_r   <= in_room_bytes;
      idx_r    <= rd_idx;
    end
  end

  // Window state, config and clear sweep
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r     <= '0;
      head_r    <= '0;
      held_r    <= '0;
      limit_r   <= chrb_pkg::LIMIT_RESET;
      clr_idx_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (cmd.clear_step && !stat.clear_last) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.ins_commit) held_r <= held_r + 1'b1;
      if (cmd.pop_commit) begin
        held_r <= held_r - 1'b1;
        exp_r  <= exp_r + 32'd1;
        head_r <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      end
    end
  end

  // Gap walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.walk_init) begin
      walk_idx_r <= head_r;
      walk_k_r   <= '0;
      seen_r     <= '0;
      found_r    <= '0;
      pend_r     <= 1'b0;
    end else if (cmd.walk_skip || cmd.walk_gap) begin
      walk_idx_r <= (walk_idx_r == LAST_IDX) ? '0 : walk_idx_r + 1'b1;
      walk_k_r   <= walk_k_r + 1'b1;
      if (cmd.walk_skip) seen_r <= seen_r + 1'b1;
      if (cmd.walk_gap) begin
        found_r    <= found_r + 7'd1;
        pend_r     <= 1'b1;
        pend_num_r <= exp_r + 32'(walk_k_r);
      end
    end
  end

  // Select the result word
  always_comb begin
    out_status_nxt = '0;
    out_num_nxt    = '0;
    out_path_nxt   = '0;
    out_len_nxt    = '0;
    out_handle_nxt = '0;
    out_last_nxt   = 1'b1;
    unique case (cmd.emit)
      chrb_pkg::EM_INSERT: out_status_nxt = ins_status;
      chrb_pkg::EM_POP: begin
        out_status_nxt = pop_status;
        if (pop_status != chrb_pkg::POP_NONE) begin
          out_num_nxt = exp_r;
          out_len_nxt = rd_data_r.len;
        end
        if (pop_status == chrb_pkg::POP_DELIVERED) begin
          out_path_nxt   = rd_data_r.path;
          out_handle_nxt = rd_data_r.handle;
        end
      end
      chrb_pkg::EM_GAP: begin
        out_status_nxt = chrb_pkg::CHK_GAP;
        out_num_nxt    = pend_num_r;
        out_last_nxt   = 1'b0;
      end
      chrb_pkg::EM_END: begin
        out_status_nxt = pend_r ? chrb_pkg::CHK_GAP : chrb_pkg::CHK_NONE;
        out_num_nxt    = pend_r ? pend_num_r : 32'd0;
      end
      default: out_last_nxt = 1'b1;
    endcase
  end

  // Output word register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != chrb_pkg::EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != chrb_pkg::EM_NONE) begin
      out_status_r <= out_status_nxt;
      out_num_r    <= out_num_nxt;
      out_path_r   <= out_path_nxt;
      out_len_r    <= out_len_nxt;
      out_handle_r <= out_handle_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chunk_number   = out_num_r;
  assign out_path_number    = out_path_r;
  assign out_length         = out_len_r;
  assign out_payload_handle = out_handle_r;
  assign out_last           = out_last_r;

  // Checks
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("held count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit != chrb_pkg::EM_NONE |-> out_free)
    else $error("result word overwrites a stalled one");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |-> rd_data_r.valid && rd_data_r.len <= room_r)
    else $error("pop commit without a deliverable head");

  a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |=> exp_r == $past(exp_r) + 32'd1)
    else $error("expected number did not advance after pop");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_commit |-> held_r < CW'(DEPTH) && !rd_data_r.valid)
    else $error("insert into a full buffer or a held slot");

endmodule
